/* rtl/core/skl_pkg.sv */
// package for the sorted key list: operation and status codes, cell
// commands and the control state type. no dependencies.
`default_nettype none

package skl_pkg;

  localparam int unsigned KEY_W    = 32;
  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STATUS_W = 3;

  typedef logic signed [KEY_W-1:0] key_t;

  // operation carried by an input beat
  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_DUMP   = 2'd2
  } kind_t;

  // status carried by a result beat
  typedef enum logic [STATUS_W-1:0] {
    STATUS_DONE      = 3'd0,
    STATUS_NOT_FOUND = 3'd1,
    STATUS_FULL      = 3'd2,
    STATUS_ENTRY     = 3'd3,
    STATUS_EMPTY     = 3'd4
  } status_t;

  // command broadcast to every cell of the row
  typedef enum logic [1:0] {
    OP_HOLD,
    OP_INSERT,
    OP_DELETE,
    OP_ROTATE
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    key_t     key;
  } cell_cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_DUMP
  } ctrl_state_t;

endpackage

`default_nettype wire

/* rtl/core/skl_if.sv */
// valid/ready channel interfaces of the sorted key list.
// depends on skl_pkg for the key, kind and status widths.
`default_nettype none

interface skl_in_if;
  logic                           valid;
  logic                           ready;
  logic [skl_pkg::KIND_W-1:0]     kind;
  logic signed [skl_pkg::KEY_W-1:0] key;

  modport source (output valid, kind, key, input ready);
  modport sink   (input valid, kind, key, output ready);
endinterface

interface skl_out_if #(
  parameter int unsigned CNT_W = 5
);
  logic                             valid;
  logic                             ready;
  logic [skl_pkg::STATUS_W-1:0]     status;
  logic signed [skl_pkg::KEY_W-1:0] value;
  logic [CNT_W-1:0]                 entries;
  logic                             last;

  modport source (output valid, status, value, entries, last, input ready);
  modport sink   (input valid, status, value, entries, last, output ready);
endinterface

`default_nettype wire

/* rtl/core/skl_cell.sv */
// one storage cell of the sorted key row: holds one key and its occupied
// bit, compares against the broadcast key. depends on skl_pkg.
`default_nettype none

module skl_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire skl_pkg::cell_cmd_t cmd,
  input  wire logic               found,
  input  wire skl_pkg::key_t      prv_key,
  input  wire logic               prv_valid,
  input  wire logic               prv_le,
  input  wire skl_pkg::key_t      nxt_key,
  input  wire logic               nxt_valid,
  input  wire skl_pkg::key_t      head_key,
  output skl_pkg::key_t           key,
  output logic                    valid,
  output logic                    le,
  output logic                    eq
);

  skl_pkg::key_t key_r, key_nxt;
  logic          valid_r, valid_nxt;
  logic          ge;

  // compares against the broadcast key
  assign le    = valid_r && (key_r <= cmd.key);
  assign ge    = valid_r && (key_r >= cmd.key);
  assign eq    = valid_r && (key_r == cmd.key);
  assign key   = key_r;
  assign valid = valid_r;

  // next key and occupancy per command
  always_comb begin
    key_nxt   = key_r;
    valid_nxt = valid_r;
    unique case (cmd.op)
      skl_pkg::OP_INSERT: begin
        // cells past the insertion point move up by one
        if (!le) begin
          key_nxt   = prv_le ? cmd.key : prv_key;
          valid_nxt = valid_r || prv_valid;
        end
      end
      skl_pkg::OP_DELETE: begin
        // from the first equal key onward everything moves down by one
        if (found && ge) begin
          key_nxt   = nxt_key;
          valid_nxt = nxt_valid;
        end
      end
      skl_pkg::OP_ROTATE: begin
        // occupied region rotates toward the head
        if (valid_r) begin
          key_nxt = nxt_valid ? nxt_key : head_key;
        end
      end
      default: begin
        key_nxt   = key_r;
        valid_nxt = valid_r;
      end
    endcase
  end

  // occupied bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // key storage
  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

endmodule

`default_nettype wire

/* rtl/core/sorted_key_list.sv */
// top level of the sorted key list: cell row, fill count, control and the
// result register. depends on skl_pkg, skl_if and skl_cell.
//
// Keeps up to CAPACITY signed 32-bit keys in ascending order in a row of
// cells, one key per cell. An insert or delete is applied to the whole row
// in the cycle its beat is accepted, every cell comparing its key with the
// broadcast key and shifting toward its neighbor, and each gives one result
// beat. A dump rotates the occupied cells toward the head once per cycle
// while the result register is free and emits the head key as one entry
// per stored key, holding off the input side meanwhile; an empty list gives
// a single result beat instead. The row is left in its original order, and
// no new beat is taken until the last entry has been loaded into the result
// register. A result that waits in the result register holds off the input
// side until it is taken. Kind code 3 is taken and ignored. There is no
// clearing pass: reset clears the occupied bits but not the stored keys.
`default_nettype none

module sorted_key_list #(
  parameter int unsigned CAPACITY = 16
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  skl_in_if.sink     in_chan,
  skl_out_if.source  out_chan
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  // cell row wiring
  skl_pkg::key_t      cell_key [CAPACITY];
  logic [CAPACITY-1:0] cell_valid;
  logic [CAPACITY-1:0] cell_le;
  logic [CAPACITY-1:0] cell_eq;
  skl_pkg::cell_cmd_t cmd;
  logic               found;

  // control registers
  skl_pkg::ctrl_state_t state_r, state_nxt;
  logic [CNT_W-1:0]     count_r, count_nxt;
  logic [CNT_W-1:0]     left_r, left_nxt;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  skl_pkg::status_t     status_r, status_nxt;
  skl_pkg::key_t        value_r, value_nxt;
  logic [CNT_W-1:0]     entries_r, entries_nxt;
  logic                 last_r, last_nxt;

  logic out_free;
  logic in_fire;
  logic full;

  assign out_free       = !out_valid_r || out_chan.ready;
  assign in_chan.ready  = (state_r == skl_pkg::ST_IDLE) && out_free;
  assign in_fire        = in_chan.valid && in_chan.ready;
  assign full           = (count_r == CAP_CNT);
  assign found          = |cell_eq;

  assign out_chan.valid   = out_valid_r;
  assign out_chan.status  = status_r;
  assign out_chan.value   = value_r;
  assign out_chan.entries = entries_r;
  assign out_chan.last    = last_r;

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    skl_pkg::key_t prv_key, nxt_key;
    logic          prv_valid, prv_le, nxt_valid;

    if (i == 0) begin : g_head
      assign prv_key   = cmd.key;
      assign prv_valid = 1'b1;
      assign prv_le    = 1'b1;
    end else begin : g_mid
      assign prv_key   = cell_key[i-1];
      assign prv_valid = cell_valid[i-1];
      assign prv_le    = cell_le[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign nxt_key   = cell_key[i];
      assign nxt_valid = 1'b0;
    end else begin : g_body
      assign nxt_key   = cell_key[i+1];
      assign nxt_valid = cell_valid[i+1];
    end

    skl_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .found     (found),
      .prv_key   (prv_key),
      .prv_valid (prv_valid),
      .prv_le    (prv_le),
      .nxt_key   (nxt_key),
      .nxt_valid (nxt_valid),
      .head_key  (cell_key[0]),
      .key       (cell_key[i]),
      .valid     (cell_valid[i]),
      .le        (cell_le[i]),
      .eq        (cell_eq[i])
    );
  end

  // control: cell command, count, dump sequencing and result beat
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    left_nxt      = left_r;
    cmd.op        = skl_pkg::OP_HOLD;
    cmd.key       = in_chan.key;
    out_valid_nxt = out_valid_r && !out_chan.ready;
    status_nxt    = status_r;
    value_nxt     = value_r;
    entries_nxt   = entries_r;
    last_nxt      = last_r;

    unique case (state_r)
      skl_pkg::ST_IDLE: begin
        if (in_fire) begin
          priority if (in_chan.kind == skl_pkg::KIND_INSERT) begin
            out_valid_nxt = 1'b1;
            value_nxt     = in_chan.key;
            last_nxt      = 1'b1;
            if (full) begin
              status_nxt  = skl_pkg::STATUS_FULL;
              entries_nxt = count_r;
            end else begin
              cmd.op      = skl_pkg::OP_INSERT;
              count_nxt   = count_r + ONE_CNT;
              status_nxt  = skl_pkg::STATUS_DONE;
              entries_nxt = count_r + ONE_CNT;
            end
          end else if (in_chan.kind == skl_pkg::KIND_DELETE) begin
            cmd.op        = skl_pkg::OP_DELETE;
            out_valid_nxt = 1'b1;
            value_nxt     = in_chan.key;
            last_nxt      = 1'b1;
            if (found) begin
              count_nxt   = count_r - ONE_CNT;
              status_nxt  = skl_pkg::STATUS_DONE;
              entries_nxt = count_r - ONE_CNT;
            end else begin
              status_nxt  = skl_pkg::STATUS_NOT_FOUND;
              entries_nxt = count_r;
            end
          end else if (in_chan.kind == skl_pkg::KIND_DUMP) begin
            if (count_r == '0) begin
              out_valid_nxt = 1'b1;
              status_nxt    = skl_pkg::STATUS_EMPTY;
              value_nxt     = '0;
              entries_nxt   = '0;
              last_nxt      = 1'b1;
            end else begin
              left_nxt  = count_r;
              state_nxt = skl_pkg::ST_DUMP;
            end
          end else begin
            // unused kind code: taken, no result
            out_valid_nxt = 1'b0;
          end
        end
      end
      skl_pkg::ST_DUMP: begin
        // one entry per free result slot
        if (out_free) begin
          cmd.op        = skl_pkg::OP_ROTATE;
          out_valid_nxt = 1'b1;
          status_nxt    = skl_pkg::STATUS_ENTRY;
          value_nxt     = cell_key[0];
          entries_nxt   = count_r;
          last_nxt      = (left_r == ONE_CNT);
          left_nxt      = left_r - ONE_CNT;
          if (left_r == ONE_CNT) begin
            state_nxt = skl_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = skl_pkg::ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= skl_pkg::ST_IDLE;
      count_r     <= '0;
      left_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      left_r      <= left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    status_r  <= status_nxt;
    value_r   <= value_nxt;
    entries_r <= entries_nxt;
    last_r    <= last_nxt;
  end

  // the number of occupied cells always equals the fill count
  a_count_matches_cells: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_valid) == 32'(count_r))
    else $error("fill count differs from occupied cells");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CAP_CNT)
    else $error("fill count above capacity");

  // a dump ends with a last beat and returns to idle
  a_dump_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == skl_pkg::ST_DUMP && out_free && left_r == ONE_CNT)
    |=> (state_r == skl_pkg::ST_IDLE && out_valid_r && last_r))
    else $error("dump did not close with a last beat");

  a_no_take_in_dump: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == skl_pkg::ST_DUMP) |-> !in_chan.ready)
    else $error("input taken during dump");

endmodule

`default_nettype wire
